// File: rtl/itp_pkg.sv
`default_nettype none

package itp_pkg;

    // Stack geometry
    localparam int STACK_DEPTH = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // Characters with a meaning to the converter
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_ADD   = 8'h2B;
    localparam logic [7:0] CH_SUB   = 8'h2D;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_TERM  = 8'h00;

    // Precedence levels
    localparam logic [1:0] PREC_MULDIV = 2'd3;
    localparam logic [1:0] PREC_ADDSUB = 2'd2;
    localparam logic [1:0] PREC_NONE   = 2'd0;

    // Command field codes
    localparam logic CMD_SYMBOL = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    // Per-cell shift control
    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

    // Stack request from the sequencer
    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] data;
    } stack_cmd_t;

    // Stack status back to the sequencer
    typedef struct packed {
        logic [7:0]       top;
        logic [7:0]       below_top;
        logic [CNT_W-1:0] count;
        logic             empty;
        logic             full;
    } stack_stat_t;

    function automatic logic [1:0] prec_of(input logic [7:0] c);
        logic [1:0] p;
        if ((c == CH_MUL) || (c == CH_DIV))
            p = PREC_MULDIV;
        else if ((c == CH_ADD) || (c == CH_SUB))
            p = PREC_ADDSUB;
        else
            p = PREC_NONE;
        return p;
    endfunction

    function automatic logic is_operand(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
               ((c >= 8'h30) && (c <= 8'h39));
    endfunction

endpackage

`default_nettype wire

// File: rtl/itp_cell.sv
`default_nettype none

module itp_cell (
    input  wire logic               clk,
    input  wire itp_pkg::cell_ctrl_t ctrl,
    input  wire logic [7:0]         up_data,
    input  wire logic [7:0]         down_data,
    output logic [7:0]              entry
);
    import itp_pkg::*;

    logic [7:0] entry_reg;
    logic [7:0] entry_next;

    // Shift toward the bottom on push, toward the top on pop, else hold
    always_comb
    begin
        if (ctrl.push)
            entry_next = up_data;
        else if (ctrl.pop)
            entry_next = down_data;
        else
            entry_next = entry_reg;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

// File: rtl/itp_stack.sv
`default_nettype none

module itp_stack (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire itp_pkg::stack_cmd_t cmd,
    output itp_pkg::stack_stat_t     stat
);
    import itp_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [7:0]       entries [STACK_DEPTH];
    cell_ctrl_t       ctrl;
    logic             empty;
    logic             full;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(STACK_DEPTH));

    // Drop a push onto a full stack, and a pop from an empty one or with a push
    assign ctrl.push = cmd.push && !full;
    assign ctrl.pop  = cmd.pop && !empty && !cmd.push;

    // Row of cells, top of stack in cell zero
    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        logic [7:0] up_d;
        logic [7:0] down_d;
        if (i == 0)
        begin : g_first
            assign up_d = cmd.data;
        end
        else
        begin : g_mid_up
            assign up_d = entries[i-1];
        end
        if (i == STACK_DEPTH - 1)
        begin : g_last
            assign down_d = entries[i];
        end
        else
        begin : g_mid_down
            assign down_d = entries[i+1];
        end
        itp_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .up_data   (up_d),
            .down_data (down_d),
            .entry     (entries[i])
        );
    end

    // Track the fill level
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.push)
            count_next = count_reg + CNT_W'(1);
        else if (ctrl.pop)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign stat.top       = entries[0];
    assign stat.below_top = entries[1];
    assign stat.count     = count_reg;
    assign stat.empty     = empty;
    assign stat.full      = full;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_full_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (full && cmd.push) |=> (count_reg == CNT_W'(STACK_DEPTH)))
        else $error("push on full stack changed count");

    a_pop_empty_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (empty && cmd.pop && !cmd.push) |=> (count_reg == '0))
        else $error("pop on empty stack changed count");

endmodule

`default_nettype wire

// File: rtl/infix_to_postfix_converter_top.sv
`default_nettype none

// Shunting-yard infix to postfix converter, one ASCII character per input
// word. An operand (letter or digit) is loaded into the result register in
// the cycle it is taken, '(' is pushed in that cycle, and unknown characters
// are dropped; none of these leaves the idle state. An operator or ')' goes
// busy and pops characters from the stack to the output one at a time; an
// operator then ends with its own push, a ')' with the discarded '(' or the
// empty check. A finish word pops every stack entry to the output and then
// sends the zero terminator. The operator stack is a row of 16 shifting
// cells that hands one entry to the output per cycle while the result side
// does not hold off. A new input word is taken only in the idle state and
// while the result register is empty or its word is taken in the same
// cycle. last_of_run marks the final result of an input word; overflow_seen
// gives with each result a sticky flag, set when a push found the stack
// full and was dropped, cleared only by reset.

module infix_to_postfix_converter_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output logic            item_ready,
    input  wire logic       command,
    input  wire logic [7:0] symbol,
    output logic            result_valid,
    input  wire logic       result_ready,
    output logic [7:0]      out_symbol,
    output logic            last_of_run,
    output logic            overflow_seen
);
    import itp_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_BUSY = 1'b1;

    localparam logic [1:0] MODE_FINISH = 2'd0;
    localparam logic [1:0] MODE_CLOSE  = 2'd1;
    localparam logic [1:0] MODE_OPER   = 2'd2;

    logic       state_reg, state_next;
    logic [1:0] mode_reg, mode_next;
    logic [7:0] sym_reg, sym_next;
    logic [1:0] prec_reg, prec_next;
    logic       ovf_reg, ovf_next;
    logic       res_valid_reg, res_valid_next;
    logic [7:0] res_sym_reg, res_sym_next;
    logic       res_last_reg, res_last_next;
    logic       res_ovf_reg, res_ovf_next;

    stack_cmd_t  scmd;
    stack_stat_t sstat;

    logic       out_free;
    logic       accept;
    logic       emit;
    logic [7:0] emit_sym;
    logic       emit_last;
    logic       one_left;

    assign out_free   = !res_valid_reg || result_ready;
    assign item_ready = (state_reg == ST_IDLE) && out_free;
    assign accept     = item_valid && item_ready;
    assign one_left   = (sstat.count == CNT_W'(1));

    itp_stack u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (scmd),
        .stat  (sstat)
    );

    // Decode a new word in idle, step the pop loop when busy
    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        sym_next   = sym_reg;
        prec_next  = prec_reg;
        ovf_next   = ovf_reg;
        scmd.push  = 1'b0;
        scmd.pop   = 1'b0;
        scmd.data  = sym_reg;
        emit       = 1'b0;
        emit_sym   = sstat.top;
        emit_last  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    sym_next  = symbol;
                    prec_next = prec_of(symbol);
                    if (command == CMD_FINISH)
                    begin
                        mode_next  = MODE_FINISH;
                        state_next = ST_BUSY;
                    end
                    else if (is_operand(symbol))
                    begin
                        emit      = 1'b1;
                        emit_sym  = symbol;
                        emit_last = 1'b1;
                    end
                    else if (symbol == CH_OPEN)
                    begin
                        scmd.push = 1'b1;
                        scmd.data = symbol;
                        if (sstat.full)
                            ovf_next = 1'b1;
                    end
                    else if (symbol == CH_CLOSE)
                    begin
                        mode_next  = MODE_CLOSE;
                        state_next = ST_BUSY;
                    end
                    else if (symbol inside {CH_MUL, CH_DIV, CH_ADD, CH_SUB})
                    begin
                        mode_next  = MODE_OPER;
                        state_next = ST_BUSY;
                    end
                end
            end
            ST_BUSY:
            begin
                case (mode_reg)
                    MODE_FINISH:
                    begin
                        if (out_free)
                        begin
                            emit = 1'b1;
                            if (sstat.empty)
                            begin
                                emit_sym   = CH_TERM;
                                emit_last  = 1'b1;
                                state_next = ST_IDLE;
                            end
                            else
                            begin
                                scmd.pop = 1'b1;
                            end
                        end
                    end
                    MODE_CLOSE:
                    begin
                        if (sstat.empty)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (sstat.top == CH_OPEN)
                        begin
                            scmd.pop   = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else if (out_free)
                        begin
                            emit      = 1'b1;
                            emit_last = one_left || (sstat.below_top == CH_OPEN);
                            scmd.pop  = 1'b1;
                        end
                    end
                    MODE_OPER:
                    begin
                        if (!sstat.empty && (prec_of(sstat.top) >= prec_reg))
                        begin
                            if (out_free)
                            begin
                                emit      = 1'b1;
                                emit_last = one_left ||
                                            (prec_of(sstat.below_top) < prec_reg);
                                scmd.pop  = 1'b1;
                            end
                        end
                        else
                        begin
                            scmd.push  = 1'b1;
                            state_next = ST_IDLE;
                            if (sstat.full)
                                ovf_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Load the result register on emit, drop the word once taken
    always_comb
    begin
        res_sym_next  = res_sym_reg;
        res_last_next = res_last_reg;
        res_ovf_next  = res_ovf_reg;
        if (emit)
        begin
            res_valid_next = 1'b1;
            res_sym_next   = emit_sym;
            res_last_next  = emit_last;
            res_ovf_next   = ovf_reg;
        end
        else if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_FINISH;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            ovf_reg       <= ovf_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg      <= sym_next;
        prec_reg     <= prec_next;
        res_sym_reg  <= res_sym_next;
        res_last_reg <= res_last_next;
        res_ovf_reg  <= res_ovf_next;
    end

    assign result_valid  = res_valid_reg;
    assign out_symbol    = res_sym_reg;
    assign last_of_run   = res_last_reg;
    assign overflow_seen = res_ovf_reg;

    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(ovf_reg))
        else $error("overflow flag cleared");

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        item_ready |-> (state_reg == ST_IDLE))
        else $error("input taken while busy");

    a_terminator: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_BUSY) && (mode_reg == MODE_FINISH) && sstat.empty && out_free)
        |=> (result_valid && (out_symbol == CH_TERM) && last_of_run &&
             (state_reg == ST_IDLE)))
        else $error("finish did not end in a terminator");

    a_no_emit_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free)
        else $error("result overwritten before taken");

endmodule

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import itp_pkg::*;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       ovf;
    } postfix_t;

    logic       clk;
    logic       rst_n        = 1'b0;
    logic       item_valid   = 1'b0;
    logic       command      = CMD_SYMBOL;
    logic [7:0] symbol       = 8'h00;
    logic       result_ready = 1'b0;
    wire        item_ready;
    wire        result_valid;
    wire  [7:0] out_symbol;
    wire        last_of_run;
    wire        overflow_seen;

    // Shadow copy of the operator stack
    logic [7:0] op_pile [STACK_DEPTH];
    int         pile_fill      = 0;
    logic       overflow_model = 1'b0;

    postfix_t   postfix_due [$];
    logic [7:0] expr_text [$];
    int         mismatch_count = 0;
    int         words_used     = 0;
    bit         no_idle        = 1'b0;

    infix_to_postfix_converter_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .command      (command),
        .symbol       (symbol),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_symbol   (out_symbol),
        .last_of_run  (last_of_run),
        .overflow_seen(overflow_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit is_alnum(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9");
    endfunction

    function automatic int rank_of(input logic [7:0] c);
        int r;
        case (c)
            CH_MUL, CH_DIV: r = 3;
            CH_ADD, CH_SUB: r = 2;
            default:        r = 0;
        endcase
        return r;
    endfunction

    function automatic bit is_arith(input logic [7:0] c);
        return (c == CH_MUL) || (c == CH_DIV) || (c == CH_ADD) || (c == CH_SUB);
    endfunction

    // Push onto the shadow stack, drop on full
    task automatic pile_push(input logic [7:0] c);
        if (pile_fill >= STACK_DEPTH)
            overflow_model = 1'b1;
        else
        begin
            op_pile[pile_fill] = c;
            pile_fill++;
        end
    endtask

    // Convert one word and queue the postfix characters it yields
    task automatic convert_word(input logic cmd, input logic [7:0] c);
        logic [7:0] emitted [$];
        postfix_t   r;
        if (cmd == CMD_FINISH)
        begin
            while (pile_fill > 0)
            begin
                pile_fill--;
                emitted.push_back(op_pile[pile_fill]);
            end
            emitted.push_back(CH_TERM);
        end
        else if (is_alnum(c))
            emitted.push_back(c);
        else if (c == CH_OPEN)
            pile_push(c);
        else if (c == CH_CLOSE)
        begin
            while (pile_fill > 0 && op_pile[pile_fill - 1] != CH_OPEN)
            begin
                pile_fill--;
                emitted.push_back(op_pile[pile_fill]);
            end
            if (pile_fill > 0)
                pile_fill--;
        end
        else if (is_arith(c))
        begin
            while (pile_fill > 0 && rank_of(op_pile[pile_fill - 1]) >= rank_of(c))
            begin
                pile_fill--;
                emitted.push_back(op_pile[pile_fill]);
            end
            pile_push(c);
        end
        foreach (emitted[i])
        begin
            r.ch   = emitted[i];
            r.last = (i == emitted.size() - 1);
            r.ovf  = overflow_model;
            postfix_due.push_back(r);
        end
    endtask

    // Offer one word and hold it until taken
    task automatic send_word(input logic cmd, input logic [7:0] c);
        while (!no_idle && $urandom_range(99) < 28)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        convert_word(cmd, c);
        if (cmd == CMD_FINISH || is_alnum(c) || is_arith(c) || c == CH_OPEN || c == CH_CLOSE)
            words_used++;
        item_valid <= 1'b1;
        command    <= cmd;
        symbol     <= c;
        do
            @(posedge clk);
        while (!item_ready);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(CMD_SYMBOL, s[i]);
    endtask

    // Hold the input until every pending character has come out
    task automatic wait_for_drain;
        item_valid <= 1'b0;
        while (postfix_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_operand;
        int r;
        r = $urandom_range(61);
        if (r < 26)
            return 8'("A" + r);
        else if (r < 52)
            return 8'("a" + r - 26);
        return 8'("0" + r - 52);
    endfunction

    function automatic logic [7:0] pick_operator;
        logic [7:0] c;
        case ($urandom_range(3))
            0:       c = CH_MUL;
            1:       c = CH_DIV;
            2:       c = CH_ADD;
            default: c = CH_SUB;
        endcase
        return c;
    endfunction

    // Build a balanced expression, nesting at most three deep
    task automatic build_expr;
        int depth;
        int terms;
        depth = 0;
        terms = $urandom_range(6, 1);
        expr_text.delete();
        while (terms > 0)
        begin
            while (depth < 3 && $urandom_range(3) == 0)
            begin
                expr_text.push_back(CH_OPEN);
                depth++;
            end
            expr_text.push_back(pick_operand());
            terms--;
            while (depth > 0 && $urandom_range(2) == 0)
            begin
                expr_text.push_back(CH_CLOSE);
                depth--;
            end
            if (terms > 0)
                expr_text.push_back(pick_operator());
        end
        while (depth > 0)
        begin
            expr_text.push_back(CH_CLOSE);
            depth--;
        end
    endtask

    function automatic logic [7:0] pick_token;
        logic [7:0] c;
        case ($urandom_range(3))
            0:       c = pick_operand();
            1:       c = pick_operator();
            2:       c = CH_OPEN;
            default: c = CH_CLOSE;
        endcase
        return c;
    endfunction

    // Operand boundaries, precedence, parentheses and ignored characters
    task automatic test_directed;
        send_text("A+z*0-9/Z");
        send_word(CMD_SYMBOL, 8'h00);
        send_word(CMD_SYMBOL, 8'hFF);
        send_word(CMD_FINISH, 8'hFF);
        send_text("(a+b) *@[`{:c");
        send_word(CMD_FINISH, 8'h00);
        // close on empty stack, then an unmatched open
        send_word(CMD_SYMBOL, CH_CLOSE);
        send_word(CMD_SYMBOL, CH_OPEN);
        send_word(CMD_FINISH, 8'h5A);
        send_word(CMD_FINISH, 8'h00);
    endtask

    // Mostly balanced expressions, some broken ones and raw noise
    task automatic test_random;
        int pick;
        int len;
        while (words_used < 130)
        begin
            no_idle = (words_used >= 80 && words_used < 120);
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                build_expr();
                foreach (expr_text[i])
                    send_word(CMD_SYMBOL, expr_text[i]);
                send_word(CMD_FINISH, 8'($urandom_range(255)));
            end
            else if (pick < 85)
            begin
                len = $urandom_range(10, 1);
                repeat (len) send_word(CMD_SYMBOL, pick_token());
                if ($urandom_range(1))
                    send_word(CMD_FINISH, 8'($urandom_range(255)));
            end
            else
                send_word(($urandom_range(9) == 0) ? CMD_FINISH : CMD_SYMBOL,
                          8'($urandom_range(255)));
        end
        no_idle = 1'b0;
        send_word(CMD_FINISH, 8'h00);
    endtask

    // Overfill the stack; the flag must then stick
    task automatic test_overflow;
        repeat (STACK_DEPTH + 1) send_word(CMD_SYMBOL, CH_OPEN);
        send_word(CMD_SYMBOL, CH_ADD);
        send_word(CMD_FINISH, 8'h00);
        send_word(CMD_SYMBOL, "q");
    endtask

    // Take results and compare against the oldest pending character
    always @(posedge clk)
    begin : check_results
        postfix_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (postfix_due.size() == 0)
                begin
                    $display("%0t: unexpected word out_symbol %h", $time, out_symbol);
                    mismatch_count++;
                end
                else
                begin
                    want = postfix_due.pop_front();
                    if (out_symbol !== want.ch)
                    begin
                        $display("%0t: out_symbol expected %h actual %h",
                                 $time, want.ch, out_symbol);
                        mismatch_count++;
                    end
                    if (last_of_run !== want.last)
                    begin
                        $display("%0t: last_of_run expected %b actual %b",
                                 $time, want.last, last_of_run);
                        mismatch_count++;
                    end
                    if (overflow_seen !== want.ovf)
                    begin
                        $display("%0t: overflow_seen expected %b actual %b",
                                 $time, want.ovf, overflow_seen);
                        mismatch_count++;
                    end
                end
            end
            result_ready <= no_idle || ($urandom_range(99) >= 28);
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        wait_for_drain();
        test_random();
        wait_for_drain();
        test_overflow();
        item_valid <= 1'b0;
        while (postfix_due.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Guard against a hang
    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// File: files.f
rtl/itp_pkg.sv
rtl/itp_cell.sv
rtl/itp_stack.sv
rtl/infix_to_postfix_converter_top.sv
sim/testbench.sv
